/* src/rbai_pkg.sv */
// ----------------------------------------------------------------------------
// rbai_pkg: shared types and arithmetic helpers
// Holds the register indexes, the request and response records of the
// shared divide and square-root unit, and the rounding and saturation
// functions of the attitude integrator.
// ----------------------------------------------------------------------------
package rbai_pkg;

  // Configuration register indexes.
  localparam logic CFG_INERTIA = 1'b0;
  localparam logic CFG_STATIC  = 1'b1;

  // Request to the shared divide / square-root unit.
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [63:0] num;       // bits still to be shifted in, most significant first
    logic [31:0] rem_init;  // partial remainder at start
    logic [31:0] den;       // divisor (unused for square root)
    logic [5:0]  steps;     // number of result bits to produce
  } dsu_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] result;
  } dsu_rsp_t;

  // One term of the quaternion derivative: which attitude component is
  // multiplied with the rate, and whether the term is subtracted.
  typedef struct packed {
    logic [1:0] qsel;
    logic       neg;
  } quat_term_t;

  // Right shift by 16 (sel17 low) or 17 (sel17 high), rounding to nearest
  // with ties away from zero.
  function automatic logic signed [65:0] rnd_shr(input logic signed [65:0] v,
                                                 input logic sel17);
    logic [65:0] mag;
    logic [65:0] m;
    mag = v[65] ? 66'(-v) : 66'(v);
    if (sel17) begin
      m = (mag + 66'h1_0000) >> 17;
    end else begin
      m = (mag + 66'h8000) >> 16;
    end
    return v[65] ? -signed'(m) : signed'(m);
  endfunction

  // Saturate a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Terms of 0.5 * (0, w) * q, component c and rate axis k.
  function automatic quat_term_t quat_term(input logic [1:0] c, input logic [1:0] k);
    quat_term_t t;
    case ({c, k})
      4'b00_00: t = '{qsel: 2'd1, neg: 1'b1};
      4'b00_01: t = '{qsel: 2'd2, neg: 1'b1};
      4'b00_10: t = '{qsel: 2'd3, neg: 1'b1};
      4'b01_00: t = '{qsel: 2'd0, neg: 1'b0};
      4'b01_01: t = '{qsel: 2'd3, neg: 1'b0};
      4'b01_10: t = '{qsel: 2'd2, neg: 1'b1};
      4'b10_00: t = '{qsel: 2'd3, neg: 1'b1};
      4'b10_01: t = '{qsel: 2'd0, neg: 1'b0};
      4'b10_10: t = '{qsel: 2'd1, neg: 1'b0};
      4'b11_00: t = '{qsel: 2'd2, neg: 1'b0};
      4'b11_01: t = '{qsel: 2'd1, neg: 1'b1};
      4'b11_10: t = '{qsel: 2'd0, neg: 1'b0};
      default:  t = '{qsel: 2'd0, neg: 1'b0};
    endcase
    return t;
  endfunction

endpackage

/* src/rbai_in_if.sv */
// ----------------------------------------------------------------------------
// rbai_in_if: input item channel
// Valid/ready channel that carries one torque or time-step item.
// ----------------------------------------------------------------------------
interface rbai_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] torque_x;
  logic signed [31:0] torque_y;
  logic signed [31:0] torque_z;
  logic        [15:0] time_step;

  modport source(output valid, mode, torque_x, torque_y, torque_z, time_step,
                 input ready);
  modport sink(input valid, mode, torque_x, torque_y, torque_z, time_step,
               output ready);
endinterface

/* src/rbai_out_if.sv */
// ----------------------------------------------------------------------------
// rbai_out_if: result item channel
// Valid/ready channel that carries the attitude and rate after an item.
// ----------------------------------------------------------------------------
interface rbai_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] att_w;
  logic signed [31:0] att_x;
  logic signed [31:0] att_y;
  logic signed [31:0] att_z;
  logic signed [31:0] rate_x;
  logic signed [31:0] rate_y;
  logic signed [31:0] rate_z;

  modport source(output valid, att_w, att_x, att_y, att_z, rate_x, rate_y, rate_z,
                 input ready);
  modport sink(input valid, att_w, att_x, att_y, att_z, rate_x, rate_y, rate_z,
               output ready);
endinterface

/* src/rbai_divsqrt.sv */
// ----------------------------------------------------------------------------
// rbai_divsqrt: shared restoring divider and square root
// Produces one quotient bit or one root bit per cycle with a single
// compare-and-subtract stage.
// ----------------------------------------------------------------------------
module rbai_divsqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rbai_pkg::dsu_req_t req_i,
  output rbai_pkg::dsu_rsp_t rsp_o
);
  import rbai_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic        sqrt_q;
  logic [5:0]  cnt_q;
  logic [33:0] rem_q;
  logic [63:0] nsh_q;
  logic [47:0] quo_q;
  logic [31:0] den_q;

  logic [33:0] trial;
  logic [33:0] dv;
  logic        ge;

  always_comb begin
    if (sqrt_q) begin
      trial = {rem_q[31:0], nsh_q[63:62]};
      dv    = {quo_q[31:0], 2'b01};
    end else begin
      trial = {rem_q[32:0], nsh_q[63]};
      dv    = {2'b00, den_q};
    end
    ge = (trial >= dv);
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sqrt_q <= req_i.is_sqrt;
      rem_q  <= {2'b00, req_i.rem_init};
      nsh_q  <= req_i.num;
      quo_q  <= '0;
      den_q  <= req_i.den;
    end else if (busy_q) begin
      rem_q <= ge ? (trial - dv) : trial;
      quo_q <= {quo_q[46:0], ge};
      nsh_q <= sqrt_q ? {nsh_q[61:0], 2'b00} : {nsh_q[62:0], 1'b0};
    end
  end

endmodule

/* src/rigid_body_attitude_integrator.sv */
// ----------------------------------------------------------------------------
// rigid_body_attitude_integrator: fixed-point attitude integrator
// Applies torque items to a pending angular acceleration and integrates
// rate and attitude quaternion on time-step items, with renormalization.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A torque item divides each of the
// three torque components by the moment of inertia on the shared restoring
// divider, one component after the other. A step item runs through one
// shared 33x33 multiplier for the rate update, the twelve quaternion
// derivative terms and the time scaling, then renormalizes: right shifting,
// the sum of squares, a square root and four divisions. Static-body items
// and torque items with zero inertia go straight to the done state. The
// input is ready whenever the sequencer is idle; the result sits in an
// output register, so a new item is taken while the previous result still
// waits to be read.
// ----------------------------------------------------------------------------
module rigid_body_attitude_integrator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  rbai_in_if.sink     in_if,
  rbai_out_if.source  out_if
);
  import rbai_pkg::*;

  // Sequencer states.
  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_TDIV_GO   = 5'd1;
  localparam logic [4:0] ST_TDIV_WAIT = 5'd2;
  localparam logic [4:0] ST_RMUL      = 5'd3;
  localparam logic [4:0] ST_RADD      = 5'd4;
  localparam logic [4:0] ST_QMUL      = 5'd5;
  localparam logic [4:0] ST_QACC      = 5'd6;
  localparam logic [4:0] ST_DLO       = 5'd7;
  localparam logic [4:0] ST_DHI       = 5'd8;
  localparam logic [4:0] ST_DADD      = 5'd9;
  localparam logic [4:0] ST_NMAG      = 5'd10;
  localparam logic [4:0] ST_NSHIFT    = 5'd11;
  localparam logic [4:0] ST_SQMUL     = 5'd12;
  localparam logic [4:0] ST_SQACC     = 5'd13;
  localparam logic [4:0] ST_SQRT_GO   = 5'd14;
  localparam logic [4:0] ST_SQRT_WAIT = 5'd15;
  localparam logic [4:0] ST_NDIV_GO   = 5'd16;
  localparam logic [4:0] ST_NDIV_WAIT = 5'd17;
  localparam logic [4:0] ST_DONE      = 5'd18;

  // Control and configuration.
  logic [4:0]  state_q;
  logic [1:0]  idx_q;
  logic [1:0]  k_q;
  logic [31:0] inertia_q;
  logic        static_q;
  logic        out_valid_q;

  // Architectural state.
  logic signed [31:0] quat_q  [4];
  logic signed [31:0] rate_q  [3];
  logic signed [31:0] accel_q [3];

  // Working registers of the current item.
  logic signed [31:0] tq_q  [3];
  logic        [15:0] dt_q;
  logic signed [47:0] d_q   [4];
  logic signed [47:0] wq_q  [4];
  logic               sgn_q [4];
  logic signed [65:0] acc_q;
  logic signed [65:0] p_q;
  logic        [31:0] len_q;

  // Output register.
  logic signed [31:0] o_att_q  [4];
  logic signed [31:0] o_rate_q [3];

  dsu_req_t dsu_req;
  dsu_rsp_t dsu_rsp;

  rbai_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dsu_req),
    .rsp_o  (dsu_rsp)
  );

  logic               accept;
  logic               out_load;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  quat_term_t         term;
  logic signed [65:0] half_prod;
  logic signed [65:0] qacc_sum;
  logic signed [65:0] dt_prod;
  logic signed [65:0] dt_rnd;
  logic signed [65:0] rate_sum;
  logic        [31:0] tmag;
  logic        [40:0] tquo;
  logic signed [41:0] tsq;
  logic signed [65:0] accel_sum;
  logic        [60:0] nnum;
  logic        [29:0] nquo;
  logic               any_big;
  logic               all_zero;

  assign accept   = in_if.valid && in_if.ready;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_if.ready);

  assign in_if.ready   = (state_q == ST_IDLE);
  assign out_if.valid  = out_valid_q;
  assign out_if.att_w  = o_att_q[0];
  assign out_if.att_x  = o_att_q[1];
  assign out_if.att_y  = o_att_q[2];
  assign out_if.att_z  = o_att_q[3];
  assign out_if.rate_x = o_rate_q[0];
  assign out_if.rate_y = o_rate_q[1];
  assign out_if.rate_z = o_rate_q[2];

  // Datapath arithmetic around the shared multiplier and divider.
  assign term      = quat_term(idx_q, k_q);
  assign half_prod = rnd_shr(p_q, 1'b1);
  assign qacc_sum  = term.neg ? (acc_q - half_prod) : (acc_q + half_prod);
  assign dt_prod   = acc_q + (p_q <<< 24);
  assign dt_rnd    = rnd_shr(dt_prod, 1'b0);
  assign rate_sum  = 66'(rate_q[idx_q]) + rnd_shr(p_q, 1'b0);

  // Torque quotient, clamped to 2^40 and given back its sign.
  assign tmag      = tq_q[idx_q][31] ? 32'(-tq_q[idx_q]) : 32'(tq_q[idx_q]);
  assign tquo      = (dsu_rsp.result > 48'h100_0000_0000) ? 41'h100_0000_0000
                                                          : dsu_rsp.result[40:0];
  assign tsq       = tq_q[idx_q][31] ? -signed'({1'b0, tquo}) : signed'({1'b0, tquo});
  assign accel_sum = 66'(accel_q[idx_q]) + 66'(tsq);

  // Normalization: numerator (m << 29) + len/2, quotient fits 30 bits.
  assign nnum = {1'b0, wq_q[idx_q][30:0], 29'b0} + {30'b0, len_q[31:1]};
  assign nquo = dsu_rsp.result[29:0];

  assign any_big  = |{wq_q[0][47:31], wq_q[1][47:31], wq_q[2][47:31], wq_q[3][47:31]};
  assign all_zero = (wq_q[0] == '0) && (wq_q[1] == '0) && (wq_q[2] == '0) &&
                    (wq_q[3] == '0);

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_RMUL: begin
        mul_a = 33'(accel_q[idx_q]);
        mul_b = {17'b0, dt_q};
      end
      ST_QMUL: begin
        mul_a = 33'(rate_q[k_q]);
        mul_b = 33'(quat_q[term.qsel]);
      end
      ST_DLO: begin
        mul_a = {9'b0, d_q[idx_q][23:0]};
        mul_b = {17'b0, dt_q};
      end
      ST_DHI: begin
        mul_a = 33'(signed'(d_q[idx_q][47:24]));
        mul_b = {17'b0, dt_q};
      end
      ST_SQMUL: begin
        mul_a = {2'b00, wq_q[idx_q][30:0]};
        mul_b = {2'b00, wq_q[idx_q][30:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Requests to the divide / square-root unit.
  always_comb begin
    dsu_req = '0;
    case (state_q)
      ST_TDIV_GO: begin
        dsu_req.start = 1'b1;
        dsu_req.num   = {tmag, 32'b0};
        dsu_req.den   = inertia_q;
        dsu_req.steps = 6'd48;
      end
      ST_SQRT_GO: begin
        dsu_req.start   = 1'b1;
        dsu_req.is_sqrt = 1'b1;
        dsu_req.num     = acc_q[63:0];
        dsu_req.steps   = 6'd32;
      end
      ST_NDIV_GO: begin
        dsu_req.start    = 1'b1;
        dsu_req.num      = {nnum[29:0], 34'b0};
        dsu_req.rem_init = {1'b0, nnum[60:30]};
        dsu_req.den      = len_q;
        dsu_req.steps    = 6'd30;
      end
      default: dsu_req = '0;
    endcase
  end

  // Sequencer, configuration and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      k_q         <= '0;
      inertia_q   <= 32'h0001_0000;
      static_q    <= 1'b0;
      out_valid_q <= 1'b0;
      quat_q[0]   <= 32'sh2000_0000;
      for (int i = 1; i < 4; i++) begin
        quat_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        rate_q[i]  <= '0;
        accel_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_INERTIA: inertia_q <= cfg_data_i;
          CFG_STATIC:  static_q  <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            idx_q <= '0;
            k_q   <= '0;
            if (static_q) begin
              state_q <= ST_DONE;
            end else if (in_if.mode) begin
              state_q <= ST_RMUL;
            end else if (inertia_q == '0) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_TDIV_GO;
            end
          end
        end
        ST_TDIV_GO: state_q <= ST_TDIV_WAIT;
        ST_TDIV_WAIT: begin
          if (dsu_rsp.done) begin
            accel_q[idx_q] <= sat32(accel_sum);
            idx_q          <= idx_q + 2'd1;
            state_q        <= (idx_q == 2'd2) ? ST_DONE : ST_TDIV_GO;
          end
        end
        ST_RMUL: state_q <= ST_RADD;
        ST_RADD: begin
          rate_q[idx_q] <= sat32(rate_sum);
          if (idx_q == 2'd2) begin
            idx_q   <= '0;
            state_q <= ST_QMUL;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= ST_RMUL;
          end
        end
        ST_QMUL: state_q <= ST_QACC;
        ST_QACC: begin
          state_q <= ST_QMUL;
          if (k_q == 2'd2) begin
            k_q   <= '0;
            idx_q <= idx_q + 2'd1;
            if (idx_q == 2'd3) begin
              state_q <= ST_DLO;
            end
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        ST_DLO: state_q <= ST_DHI;
        ST_DHI: state_q <= ST_DADD;
        ST_DADD: begin
          idx_q   <= idx_q + 2'd1;
          state_q <= (idx_q == 2'd3) ? ST_NMAG : ST_DLO;
        end
        ST_NMAG: begin
          // The pending acceleration has been used up by the rate update.
          for (int i = 0; i < 3; i++) begin
            accel_q[i] <= '0;
          end
          if (all_zero) begin
            // A quaternion of zero norm stays zero.
            for (int i = 0; i < 4; i++) begin
              quat_q[i] <= '0;
            end
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_NSHIFT;
          end
        end
        ST_NSHIFT: begin
          if (!any_big) begin
            idx_q   <= '0;
            state_q <= ST_SQMUL;
          end
        end
        ST_SQMUL: state_q <= ST_SQACC;
        ST_SQACC: begin
          idx_q   <= idx_q + 2'd1;
          state_q <= (idx_q == 2'd3) ? ST_SQRT_GO : ST_SQMUL;
        end
        ST_SQRT_GO: state_q <= ST_SQRT_WAIT;
        ST_SQRT_WAIT: begin
          if (dsu_rsp.done) begin
            idx_q   <= '0;
            state_q <= ST_NDIV_GO;
          end
        end
        ST_NDIV_GO: state_q <= ST_NDIV_WAIT;
        ST_NDIV_WAIT: begin
          if (dsu_rsp.done) begin
            quat_q[idx_q] <= sgn_q[idx_q] ? -signed'({2'b00, nquo})
                                          : signed'({2'b00, nquo});
            idx_q         <= idx_q + 2'd1;
            state_q       <= (idx_q == 2'd3) ? ST_DONE : ST_NDIV_GO;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers; they carry no reset.
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;

    if (accept) begin
      tq_q[0] <= in_if.torque_x;
      tq_q[1] <= in_if.torque_y;
      tq_q[2] <= in_if.torque_z;
      dt_q    <= in_if.time_step;
      acc_q   <= '0;
    end

    case (state_q)
      ST_QACC: begin
        if (k_q == 2'd2) begin
          d_q[idx_q] <= qacc_sum[47:0];
          acc_q      <= '0;
        end else begin
          acc_q <= qacc_sum;
        end
      end
      ST_DHI: acc_q <= p_q;
      ST_DADD: begin
        wq_q[idx_q] <= 48'(quat_q[idx_q]) + dt_rnd[47:0];
        acc_q       <= '0;
      end
      ST_NMAG: begin
        for (int i = 0; i < 4; i++) begin
          sgn_q[i] <= wq_q[i][47];
          wq_q[i]  <= wq_q[i][47] ? -wq_q[i] : wq_q[i];
        end
      end
      ST_NSHIFT: begin
        if (any_big) begin
          for (int i = 0; i < 4; i++) begin
            wq_q[i] <= wq_q[i] >> 1;
          end
        end
      end
      ST_SQACC: acc_q <= acc_q + p_q;
      ST_SQRT_WAIT: begin
        if (dsu_rsp.done) begin
          len_q <= dsu_rsp.result[31:0];
        end
      end
      default: ;
    endcase

    if (out_load) begin
      for (int i = 0; i < 4; i++) begin
        o_att_q[i] <= quat_q[i];
      end
      for (int i = 0; i < 3; i++) begin
        o_rate_q[i] <= rate_q[i];
      end
    end
  end

endmodule

/* bench/tb_rigid_body_attitude_integrator.sv */
// ----------------------------------------------------------------------------
// tb_rigid_body_attitude_integrator: regression bench of the attitude integrator
// Drives torque and time-step items through the valid/ready channels, predicts
// attitude and rate with a model of its own in 64-bit arithmetic, and compares
// every result as a whole pose, under several phases of idling and back pressure.
// ----------------------------------------------------------------------------
module tb_rigid_body_attitude_integrator;
  import rbai_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [31:0] cfg_data_i;

  rbai_in_if  in_if ();
  rbai_out_if out_if ();

  rigid_body_attitude_integrator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  // One expected result: the attitude quaternion and the angular rate.
  typedef struct packed {
    logic [31:0] w, x, y, z, rx, ry, rz;
  } pose_t;

  // One row of the directed table. A row with has_pose set carries the
  // expected result, held against the predictor; all others use the predictor.
  typedef struct {
    logic        mode;
    logic [31:0] tx, ty, tz;
    logic [15:0] dt;
    logic        has_pose;
    pose_t       pose;
  } stim_row_t;

  localparam pose_t POSE_RESET = '{32'h2000_0000, 0, 0, 0, 0, 0, 0};
  localparam logic  MODE_TORQUE = 1'b0;
  localparam logic  MODE_STEP   = 1'b1;
  localparam int    CYCLE_LIMIT = 3_000_000;

  // Predictor state, kept in wide signed words.
  longint    inertia_q;
  bit        frozen;
  longint    att_q[4];
  longint    rate_q[3];
  longint    accel_q[3];

  pose_t     pose_queue[$];
  int        failures;
  longint    cycle_count;

  // Idling control, written by the main process; hold_cycles is counted by the receiver.
  int        send_idle_pct;
  int        recv_stall_pct;
  bit        recv_hold;
  int        hold_cycles;

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rigid_body_attitude_integrator regression: fail");
      $finish;
    end
  end

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_shift(longint v, int s);
    longint unsigned m;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Rescale the quaternion to unit length; an all-zero quaternion stays zero.
  function automatic void renormalize();
    longint unsigned m[4];
    longint unsigned mx, sum, len, r;
    int s;
    mx = 0;
    sum = 0;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      m[i] = att_q[i] < 0 ? -att_q[i] : att_q[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return;
    while ((mx >> s) >= (64'd1 << 31)) s++;
    for (int i = 0; i < 4; i++) begin
      m[i] >>= s;
      sum += m[i] * m[i];
    end
    len = int_sqrt(sum);
    if (len == 0) return;
    for (int i = 0; i < 4; i++) begin
      r = ((m[i] << 29) + (len >> 1)) / len;
      att_q[i] = att_q[i] < 0 ? -longint'(r) : longint'(r);
    end
  endfunction

  function automatic void integrate_step(logic [15:0] dt_raw);
    longint dt;
    longint d[4];
    longint w[3];
    dt = dt_raw;
    for (int i = 0; i < 3; i++) begin
      rate_q[i] = sat_word(rate_q[i] + round_shift(accel_q[i] * dt, 16));
      w[i] = rate_q[i];
    end
    d[0] = -(round_shift(w[0] * att_q[1], 17) + round_shift(w[1] * att_q[2], 17)
             + round_shift(w[2] * att_q[3], 17));
    d[1] = round_shift(w[0] * att_q[0], 17) + round_shift(w[1] * att_q[3], 17)
           - round_shift(w[2] * att_q[2], 17);
    d[2] = -round_shift(w[0] * att_q[3], 17) + round_shift(w[1] * att_q[0], 17)
           + round_shift(w[2] * att_q[1], 17);
    d[3] = round_shift(w[0] * att_q[2], 17) - round_shift(w[1] * att_q[1], 17)
           + round_shift(w[2] * att_q[0], 17);
    for (int i = 0; i < 4; i++) att_q[i] += round_shift(d[i] * dt, 16);
    renormalize();
    for (int i = 0; i < 3; i++) accel_q[i] = 0;
  endfunction

  function automatic void accumulate_torque(logic [31:0] tx, logic [31:0] ty,
                                            logic [31:0] tz);
    logic [31:0] tv[3];
    longint t;
    longint unsigned quo;
    tv = '{tx, ty, tz};
    for (int i = 0; i < 3; i++) begin
      t = longint'(signed'(tv[i]));
      quo = ((t < 0 ? -t : t) << 16) / inertia_q;
      if (quo > (64'd1 << 40)) quo = 64'd1 << 40;
      accel_q[i] = sat_word(accel_q[i] + (t < 0 ? -longint'(quo) : longint'(quo)));
    end
  endfunction

  function automatic pose_t current_pose();
    return '{att_q[0][31:0], att_q[1][31:0], att_q[2][31:0], att_q[3][31:0],
             rate_q[0][31:0], rate_q[1][31:0], rate_q[2][31:0]};
  endfunction

  // Advance the predictor by one item and return the pose it leaves.
  function automatic pose_t predict_pose(logic mode, logic [31:0] tx, logic [31:0] ty,
                                         logic [31:0] tz, logic [15:0] dt);
    if (!frozen) begin
      if (mode == MODE_TORQUE) begin
        if (inertia_q != 0) accumulate_torque(tx, ty, tz);
      end else begin
        integrate_step(dt);
      end
    end
    return current_pose();
  endfunction

  task automatic reset_prediction();
    inertia_q = 65536;
    frozen = 0;
    att_q = '{64'sd536870912, 0, 0, 0};
    rate_q = '{0, 0, 0};
    accel_q = '{0, 0, 0};
  endtask

  // Registers are only written while the block is idle.
  task automatic write_reg(logic idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_INERTIA) inertia_q = data;
    else frozen = data[0];
  endtask

  task automatic wait_drained();
    while (pose_queue.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Offer one item and wait until it is taken. The expectation is queued
  // at the accepting edge, ahead of any result that may follow it.
  task automatic send_item(logic mode, logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                           logic [15:0] dt, bit has_pose, pose_t pose);
    pose_t p;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.mode      <= mode;
    in_if.torque_x  <= tx;
    in_if.torque_y  <= ty;
    in_if.torque_z  <= tz;
    in_if.time_step <= dt;
    do @(posedge clk_i); while (!in_if.ready);
    p = predict_pose(mode, tx, ty, tz, dt);
    if (has_pose && p != pose)
      $display("%0t directed row disagrees with predictor: table %h predictor %h",
               $time, pose, p);
    pose_queue.push_back(has_pose ? pose : p);
    in_if.valid <= 1'b0;
    // The block is busy right after it takes an item, so this edge costs
    // nothing and keeps the next offer out of the current time step.
    @(posedge clk_i);
  endtask

  task automatic send_random(int count);
    logic [31:0] tv[3];
    for (int n = 0; n < count; n++) begin
      // Torques are scaled over a wide range of magnitudes so that both
      // small drift and saturation are reached.
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(3))
          0: tv[i] = $urandom;
          1: tv[i] = $urandom >> $urandom_range(31);
          2: tv[i] = -($urandom >> $urandom_range(31));
          default: tv[i] = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
      end
      send_item($urandom_range(2) == 0 ? MODE_STEP : MODE_TORQUE, tv[0], tv[1], tv[2],
                $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom >> 22), 0, '0);
    end
  endtask

  // Receiver: stalls at random, or holds off entirely while recv_hold is
  // set, counting the stretch in its own cycles.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (recv_hold) begin
      out_if.ready <= 1'b0;
      hold_cycles  <= hold_cycles + 1;
    end else begin
      out_if.ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // Checker: compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    pose_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.att_w, out_if.att_x, out_if.att_y, out_if.att_z,
              out_if.rate_x, out_if.rate_y, out_if.rate_z};
      if (pose_queue.size() == 0) begin
        $display("%0t result with nothing expected: actual %h", $time, got);
        failures++;
      end else begin
        want = pose_queue.pop_front();
        if (got != want) begin
          $display("%0t mismatch: expected %h actual %h", $time, want, got);
          failures++;
        end
      end
    end
  end

  stim_row_t directed[$];

  initial begin
    cycle_count    = 0;
    failures       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold      = 0;
    hold_cycles    = 0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_INERTIA;
    cfg_data_i     = '0;
    in_if.valid    = 1'b0;
    in_if.mode     = MODE_TORQUE;
    in_if.torque_x = '0;
    in_if.torque_y = '0;
    in_if.torque_z = '0;
    in_if.time_step = '0;
    reset_prediction();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a zero time step and a zero torque on the reset pose,
    // extreme torques and extreme time steps.
    directed = '{
      '{MODE_STEP,   0, 0, 0, 16'h0000, 1, POSE_RESET},
      '{MODE_TORQUE, 0, 0, 0, 16'hffff, 1, POSE_RESET},
      '{MODE_TORQUE, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 0, 0, '0},
      '{MODE_TORQUE, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0, 0, '0},
      '{MODE_STEP,   0, 0, 0, 16'hffff, 0, '0},
      '{MODE_STEP,   0, 0, 0, 16'h0001, 0, '0},
      '{MODE_TORQUE, 32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 0, 0, '0},
      '{MODE_STEP,   32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'h8000, 0, '0},
      '{MODE_STEP,   0, 0, 0, 16'h0000, 0, '0}
    };
    foreach (directed[i])
      send_item(directed[i].mode, directed[i].tx, directed[i].ty, directed[i].tz,
                directed[i].dt, directed[i].has_pose, directed[i].pose);
    wait_drained();

    // Static body: items repeat the current pose.
    write_reg(CFG_STATIC, 32'd1);
    send_item(MODE_TORQUE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, '0);
    send_item(MODE_STEP, 0, 0, 0, 16'hffff, 0, '0);
    wait_drained();
    write_reg(CFG_STATIC, 32'd0);
    // Zero inertia: torque does nothing.
    write_reg(CFG_INERTIA, 32'd0);
    send_item(MODE_TORQUE, 32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678, 0, 0, '0);
    send_item(MODE_STEP, 0, 0, 0, 16'h1000, 0, '0);
    wait_drained();
    // Smallest nonzero inertia drives the quotient clamp and saturation.
    write_reg(CFG_INERTIA, 32'd1);
    send_item(MODE_TORQUE, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 0, 0, '0);
    send_item(MODE_STEP, 0, 0, 0, 16'hffff, 0, '0);
    send_item(MODE_STEP, 0, 0, 0, 16'h0010, 0, '0);
    wait_drained();

    // Random phases over several inertia settings and idling patterns.
    write_reg(CFG_INERTIA, 32'hffff_ffff);
    send_random(150);
    wait_drained();
    write_reg(CFG_INERTIA, 32'h0001_0000);
    send_idle_pct = 83;
    send_random(200);
    wait_drained();
    write_reg(CFG_INERTIA, $urandom);
    send_idle_pct  = 0;
    recv_stall_pct = 83;
    send_random(200);
    wait_drained();
    write_reg(CFG_INERTIA, 32'h0000_4000 + $urandom_range(32'h0010_0000));
    send_idle_pct  = 32;
    recv_stall_pct = 32;
    send_random(250);
    wait_drained();

    // Hold the receiver off while items keep coming, so the block fills up
    // and stalls its input; the hold is released after a long stretch.
    fork
      begin
        recv_hold = 1;
        wait (hold_cycles >= 2000);
        recv_hold = 0;
      end
      begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(20);
      end
    join
    wait_drained();

    // Mixed phases with one static spell and heavy idling.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_INERTIA, ph[0] ? $urandom : 32'h0000_8000 + $urandom_range(32'h40000));
      write_reg(CFG_STATIC, {31'b0, ph == 5});
      send_idle_pct  = ph[1] ? 83 : 0;
      recv_stall_pct = ph[2] ? 83 : 0;
      send_random(100);
      wait_drained();
    end
    write_reg(CFG_STATIC, 32'd0);
    send_random(30);
    wait_drained();
    repeat (300) @(posedge clk_i);

    if (failures == 0 && pose_queue.size() == 0) begin
      $display("rigid_body_attitude_integrator regression: pass");
    end else begin
      $display("rigid_body_attitude_integrator regression: fail");
    end
    $finish;
  end

endmodule

/* rigid_body_attitude_integrator.f */
src/rbai_pkg.sv
src/rbai_in_if.sv
src/rbai_out_if.sv
src/rbai_divsqrt.sv
src/rigid_body_attitude_integrator.sv
bench/tb_rigid_body_attitude_integrator.sv
